FILE: rtl/core/itaf_pkg.sv
// Shared types, format codes and a digit helper for the integer-to-ASCII formatter.
// No dependencies; imported by itaf_dabble, int_to_ascii_formatter_unit and tb_top.
package itaf_pkg;

  localparam int WordBits   = 32;
  localparam int DecDigits  = 10;
  localparam int HexDigits  = 8;
  localparam int DigitBits  = 4;
  localparam int BcdBits    = DecDigits * DigitBits;
  localparam int TopLo      = BcdBits - DigitBits;
  localparam int CntBits    = 4;
  localparam int CharBits   = 8;
  localparam int KindBits   = 3;
  localparam int IterBits   = $clog2(WordBits);

  localparam logic [KindBits-1:0] KindSdec = 3'd0;
  localparam logic [KindBits-1:0] KindUdec = 3'd1;
  localparam logic [KindBits-1:0] KindLhex = 3'd2;
  localparam logic [KindBits-1:0] KindUhex = 3'd3;

  localparam logic [CharBits-1:0] CharMinus = 8'h2d;
  localparam logic [CharBits-1:0] CharZero  = 8'h30;
  localparam logic [CharBits-1:0] CharLowA  = 8'h61;
  localparam logic [CharBits-1:0] CharUpA   = 8'h41;

  typedef struct packed {
    logic [KindBits-1:0] kind;
    logic [WordBits-1:0] value;
  } in_t;

  typedef struct packed {
    logic [CharBits-1:0] char_code;
    logic [CntBits-1:0]  char_count;
    logic                last;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // One hex or decimal digit to its ASCII code.
  function automatic logic [CharBits-1:0] digit_char(input logic [DigitBits-1:0] d,
                                                     input logic upper);
    logic [CharBits-1:0] base;
    base = upper ? CharUpA : CharLowA;
    if (d < 4'd10) begin
      return CharZero + {4'd0, d};
    end else begin
      return base + {4'd0, d} - 8'd10;
    end
  endfunction

endpackage

FILE: rtl/core/itaf_dabble.sv
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
// Depends on itaf_pkg.
module itaf_dabble (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [itaf_pkg::WordBits-1:0]  mag,
  output logic                           done,
  output logic [itaf_pkg::BcdBits-1:0]   bcd
);
  import itaf_pkg::*;

  logic [WordBits-1:0] bin;
  logic [IterBits-1:0] iter;
  logic                busy;
  logic [BcdBits-1:0]  adj;

  // Every BCD digit of 5 or more gets +3 before the shift.
  always_comb begin
    for (int i = 0; i < DecDigits; i++) begin
      adj[i*DigitBits +: DigitBits] = (bcd[i*DigitBits +: DigitBits] >= 4'd5)
          ? bcd[i*DigitBits +: DigitBits] + 4'd3
          : bcd[i*DigitBits +: DigitBits];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= busy && (iter == IterBits'(WordBits - 1));
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        iter <= iter + 1'b1;
        if (iter == IterBits'(WordBits - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= mag;
      bcd <= '0;
    end else if (busy) begin
      bin <= {bin[WordBits-2:0], 1'b0};
      bcd <= {adj[BcdBits-2:0], bin[WordBits-1]};
    end
  end

endmodule

FILE: rtl/core/int_to_ascii_formatter_unit.sv
// Top level of the integer-to-ASCII formatter: decimal or hex text, one char per transfer.
// Depends on itaf_pkg and itaf_dabble.
//
//   channel | direction | payload            | handshake
//   --------+-----------+--------------------+------------------------
//   in      | to unit   | in_t  (kind,value) | in_valid / in_stall
//   out     | from unit | out_t (char,count, | out_valid / out_stall
//           |           |        last)       |
//
// One item at a time. Decimal: the item is accepted and run through the shift/add-3
// converter, then leading zeros are suppressed one at a time in the skip state (up
// to 9), then a minus sign if negative and the digits go out, one character per
// transfer as out_stall allows. Hex skips the converter: 8 nibbles, up to 7
// skipped; kinds 4 to 7 emit nothing. Reset (rst, synchronous) returns to idle and
// drops out_valid. out_stall only delays character transfers; the last character
// may still wait while a new item is taken.
module int_to_ascii_formatter_unit (
  input  logic            clk,
  input  logic            rst,
  input  itaf_pkg::in_t   in_data,
  input  logic            in_valid,
  output logic            in_stall,
  output itaf_pkg::out_t  out_data,
  output logic            out_valid,
  input  logic            out_stall
);
  import itaf_pkg::*;

  state_t              state, state_next;
  logic [BcdBits-1:0]  dig, dig_next;
  logic [CntBits-1:0]  ndig, ndig_next;
  logic [CntBits-1:0]  cnt, cnt_next;
  logic                neg, neg_next;
  logic                upper, upper_next;
  out_t                out_next;
  logic                out_valid_next;
  logic                start;
  logic                slot;
  logic                conv_done;
  logic [WordBits-1:0] mag;
  logic [BcdBits-1:0]  bcd;

  itaf_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mag   (mag),
    .done  (conv_done),
    .bcd   (bcd)
  );

  assign in_stall = (state != ST_IDLE);
  assign slot     = !out_valid || !out_stall;
  assign mag      = (in_data.kind == KindSdec && in_data.value[WordBits-1])
                    ? (~in_data.value + 1'b1) : in_data.value;

  always_comb begin
    state_next     = state;
    dig_next       = dig;
    ndig_next      = ndig;
    cnt_next       = cnt;
    neg_next       = neg;
    upper_next     = upper;
    out_next       = out_data;
    out_valid_next = out_valid && out_stall;
    start          = 1'b0;

    case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (in_valid) begin
          case (in_data.kind)
            KindSdec, KindUdec: begin
              start      = 1'b1;
              neg_next   = (in_data.kind == KindSdec) && in_data.value[WordBits-1];
              upper_next = 1'b0;
              state_next = ST_CONV;
            end
            KindLhex, KindUhex: begin
              dig_next   = {in_data.value, {(BcdBits - WordBits){1'b0}}};
              ndig_next  = CntBits'(HexDigits);
              neg_next   = 1'b0;
              upper_next = (in_data.kind == KindUhex);
              state_next = ST_SKIP;
            end
            default: ;
          endcase
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          dig_next   = bcd;
          ndig_next  = CntBits'(DecDigits);
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros but keep at least one digit
        if (ndig > 4'd1 && dig[BcdBits-1:TopLo] == '0) begin
          dig_next  = {dig[TopLo-1:0], {DigitBits{1'b0}}};
          ndig_next = ndig - 1'b1;
        end else begin
          state_next = neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot) begin
          out_next.char_code  = CharMinus;
          out_next.char_count = cnt + 1'b1;
          out_next.last       = 1'b0;
          out_valid_next      = 1'b1;
          cnt_next            = cnt + 1'b1;
          state_next          = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot) begin
          out_next.char_code  = digit_char(dig[BcdBits-1:TopLo], upper);
          out_next.char_count = cnt + 1'b1;
          out_next.last       = (ndig == 4'd1);
          out_valid_next      = 1'b1;
          cnt_next            = cnt + 1'b1;
          dig_next            = {dig[TopLo-1:0], {DigitBits{1'b0}}};
          ndig_next           = ndig - 1'b1;
          if (ndig == 4'd1) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
      ndig      <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      cnt       <= cnt_next;
      ndig      <= ndig_next;
    end
  end

  always_ff @(posedge clk) begin
    dig      <= dig_next;
    neg      <= neg_next;
    upper    <= upper_next;
    out_data <= out_next;
  end

endmodule

FILE: sim/tb_top.sv
// Self-checking bench for int_to_ascii_formatter_unit: words go in, their decimal/hex text is
// predicted per character and checked transfer by transfer on the output channel.
// Depends on itaf_pkg and the formatter RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import itaf_pkg::*;

  // Kinds the package leaves unnamed: 4 prints nothing, 5..7 behave the same.
  localparam logic [KindBits-1:0] KindNone = 3'd4;
  localparam logic [KindBits-1:0] KindLast = 3'd7;
  localparam int TextWords    = 500;
  localparam int IdleLimit    = 3000;
  localparam int DrainCycles  = 100;
  localparam int MaxReports   = 10;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  in_t  in_data   = '0;
  logic in_valid  = 1'b0;
  logic in_stall;
  out_t out_data;
  logic out_valid;
  logic out_stall = 1'b0;

  in_t  pending_words[$];
  out_t expected_chars[$];

  int   n_words    = 0;
  int   n_silent   = 0;
  int   n_chars    = 0;
  int   n_errors   = 0;
  int   idle_count = 0;
  int   cycle_cnt  = 0;

  int   burst_left = 0;
  int   gap_left   = 0;
  int   stall_mode = 0;
  int   mode_left  = 0;

  int_to_ascii_formatter_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Expected text of one word, queued one character per output transfer.
  function automatic void queue_text(input in_t word);
    logic [32:0]         mag;
    logic [CharBits-1:0] text[$];
    logic [3:0]          d;
    int                  radix;
    bit                  upper;
    out_t                ch;
    mag   = {1'b0, word.value};
    upper = 1'b0;
    radix = 10;
    case (word.kind)
      KindSdec: begin
        // negate in 33 bits so the most negative word keeps its full magnitude
        if (word.value[WordBits-1]) mag = 33'h1_0000_0000 - {1'b0, word.value};
      end
      KindUdec: radix = 10;
      KindLhex: radix = 16;
      KindUhex: begin
        radix = 16;
        upper = 1'b1;
      end
      default: return;
    endcase
    do begin
      d = 4'(mag % radix);
      if (d < 4'd10) text.push_front(CharZero + 8'(d));
      else text.push_front((upper ? CharUpA : CharLowA) + 8'(d - 4'd10));
      mag = mag / radix;
    end while (mag != 0);
    if (word.kind == KindSdec && word.value[WordBits-1]) text.push_front(CharMinus);
    foreach (text[i]) begin
      ch.char_code  = text[i];
      ch.char_count = CntBits'(i + 1);
      ch.last       = (i == text.size() - 1);
      expected_chars.push_back(ch);
    end
  endfunction

  task automatic report_mismatch(input string what, input out_t want, input out_t got);
    n_errors++;
    if (n_errors <= MaxReports)
      $display("%0t: %s: expected char %02h count %0d last %0b, got char %02h count %0d last %0b",
               $realtime, what, want.char_code, want.char_count, want.last,
               got.char_code, got.char_count, got.last);
  endtask

  // Sender: bursts of back-to-back words separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        queue_text(in_data);
        if (in_data.kind >= KindNone) n_silent++;
        else n_words++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          in_data  <= pending_words.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern switches between free-running, light, heavy and periodic.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(50, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= cycle_cnt[1];
      endcase
    end
  end

  // Checker: every character transfer against the oldest expectation.
  always @(posedge clk) begin : check_chars
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      n_chars++;
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected character", '0, out_data);
      end else begin
        want = expected_chars.pop_front();
        if (out_data.char_code !== want.char_code || out_data.char_count !== want.char_count ||
            out_data.last !== want.last)
          report_mismatch("character mismatch", want, out_data);
      end
    end
  end

  // Watchdog: cycles without any transfer on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_count <= 0;
    end else if (idle_count >= IdleLimit) begin
      $display("timeout: no transfer for %0d cycles, %0d characters outstanding",
               idle_count, expected_chars.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin : stimulus
    logic [KindBits-1:0] kind;
    logic [WordBits-1:0] value;
    int                  text_count;
    int                  pow;
    int                  reps;

    // extremes, every kind, zero, the most negative word and the silent kinds
    pending_words.push_back('{kind: KindSdec, value: 32'h0000_0000});
    pending_words.push_back('{kind: KindSdec, value: 32'h8000_0000});
    pending_words.push_back('{kind: KindSdec, value: 32'h7FFF_FFFF});
    pending_words.push_back('{kind: KindSdec, value: 32'hFFFF_FFFF});
    pending_words.push_back('{kind: KindSdec, value: 32'd123});
    pending_words.push_back('{kind: KindUdec, value: 32'h0000_0000});
    pending_words.push_back('{kind: KindUdec, value: 32'hFFFF_FFFF});
    pending_words.push_back('{kind: KindUdec, value: 32'd1000000000});
    pending_words.push_back('{kind: KindUdec, value: 32'd9});
    pending_words.push_back('{kind: KindLhex, value: 32'h0000_0000});
    pending_words.push_back('{kind: KindLhex, value: 32'hFFFF_FFFF});
    pending_words.push_back('{kind: KindLhex, value: 32'hDEAD_BEEF});
    pending_words.push_back('{kind: KindLhex, value: 32'h0000_000F});
    pending_words.push_back('{kind: KindUhex, value: 32'h0000_0000});
    pending_words.push_back('{kind: KindUhex, value: 32'hABCD_EF01});
    pending_words.push_back('{kind: KindUhex, value: 32'h1000_0000});
    for (int k = KindNone; k <= KindLast; k++)
      pending_words.push_back('{kind: KindBits'(k), value: $urandom});
    pending_words.push_back('{kind: KindUdec, value: 32'h8000_0000});

    text_count = 0;
    while (text_count < TextWords) begin
      if ($urandom_range(0, 19) == 0) begin
        kind = KindBits'($urandom_range(KindNone, KindLast));
      end else begin
        kind = KindBits'($urandom_range(KindSdec, KindUhex));
        text_count++;
      end
      case ($urandom_range(0, 6))
        0: value = $urandom_range(0, 15);
        1: value = $urandom_range(0, 99999);
        2: begin
          // around a power of ten, where the digit count changes
          pow  = 1;
          reps = $urandom_range(0, 9);
          repeat (reps) pow = pow * 10;
          value = WordBits'(pow) + $urandom_range(0, 2) - 1;
        end
        3: value = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 + $urandom_range(0, 3)
                                              : 32'hFFFF_FFFF - $urandom_range(0, 3);
        4: value = $urandom >> $urandom_range(0, 31);
        5: value = 32'h0 - $urandom_range(1, 1000);
        default: value = $urandom;
      endcase
      pending_words.push_back('{kind: kind, value: value});
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("formatted %0d words (%0d more of the silent kinds), %0d characters checked",
             n_words, n_silent, n_chars);
    $display("%0d mismatches", n_errors);
    if (n_errors == 0 && expected_chars.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
